### design/bsfd_pkg.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame decoder package
// Framing codes, field widths and default capacity shared by the decoder.
// ----------------------------------------------------------------------------
package bsfd_pkg;

   typedef logic [7:0] byte_type;

   // Framing codes on the serial line.
   localparam byte_type SOF_CODE = 8'hf0;
   localparam byte_type EOF_CODE = 8'hf1;
   localparam byte_type ESC_CODE = 8'hf2;
   localparam byte_type ESC_OR   = 8'hf0;

   // Default message capacity in bytes (legal range 2 to 8).
   localparam int MSG_BYTES_DEFAULT = 8;

   // Result field widths.
   localparam int CLASS_W = 3;
   localparam int ID_W    = 5;
   localparam int ARGS_W  = 48;
   localparam int COUNT_W = 4;

endpackage

### design/byte_stuffed_frame_decoder.sv
// ----------------------------------------------------------------------------
// Byte-stuffed frame decoder
// Rebuilds framed, escape-stuffed messages from a serial byte stream and
// reports each completed frame as one decoded result item.
// ----------------------------------------------------------------------------
//
//   Channel   Ports           Direction   Carries
//   -------   -------------   ---------   ------------------------------------
//   request   req_*           in          one received byte per item
//   response  rsp_*           out         one decoded message per closed frame
//
// The block accepts one byte per cycle while no end-of-frame byte is stalled. A
// byte is captured in an input register and decoded while it is held there;
// a result is written to the output register when its end-of-frame byte is decoded.
// Reset clears the framing state and both valid flags; no clearing pass runs.
// A full output register stalls only an end-of-frame byte; all other bytes
// keep flowing while an earlier result waits to be taken.
//
module byte_stuffed_frame_decoder #(
   parameter int MSG_BYTES = bsfd_pkg::MSG_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsfd_pkg::CLASS_W-1:0]  rsp_msg_class,
   output logic [bsfd_pkg::ID_W-1:0]     rsp_node_id,
   output logic [7:0]                    rsp_opcode,
   output logic [bsfd_pkg::ARGS_W-1:0]   rsp_args,
   output logic [bsfd_pkg::COUNT_W-1:0]  rsp_byte_count,
   output logic                          rsp_too_long
);

   localparam logic [bsfd_pkg::COUNT_W-1:0] CapCount = bsfd_pkg::COUNT_W'(MSG_BYTES);

   // Input register.
   logic                         in_valid_ff;
   bsfd_pkg::byte_type           in_byte_ff;

   // Framing state.
   logic                         in_frame_ff, in_frame_in;
   logic                         esc_pending_ff, esc_pending_in;
   logic [bsfd_pkg::COUNT_W-1:0] fill_count_ff, fill_count_in;
   logic                         overflow_ff, overflow_in;
   bsfd_pkg::byte_type           msg_data_ff [MSG_BYTES];

   // Output register.
   logic                         rsp_valid_ff;
   logic [bsfd_pkg::CLASS_W-1:0] rsp_class_ff;
   logic [bsfd_pkg::ID_W-1:0]    rsp_id_ff;
   bsfd_pkg::byte_type           rsp_opcode_ff;
   logic [bsfd_pkg::ARGS_W-1:0]  rsp_args_ff;
   logic [bsfd_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                         rsp_too_long_ff;

   // Decode controls.
   logic                         emit_now;
   logic                         out_free;
   logic                         advance;
   logic                         clear_buf;
   logic                         write_en;
   bsfd_pkg::byte_type           store_byte;
   logic [bsfd_pkg::ARGS_W-1:0]  args_in;

   // Handshake: only an end byte needs room in the output register.
   assign emit_now  = in_valid_ff && in_frame_ff && (in_byte_ff == bsfd_pkg::EOF_CODE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!emit_now || out_free);
   assign req_ready = !in_valid_ff || advance;

   // Input register captures each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Next framing state for the byte held in the input register.
   always_comb begin
      logic store;
      store          = 1'b0;
      in_frame_in    = in_frame_ff;
      esc_pending_in = esc_pending_ff;
      fill_count_in  = fill_count_ff;
      overflow_in    = overflow_ff;
      clear_buf      = 1'b0;
      write_en       = 1'b0;
      store_byte     = in_byte_ff;
      if (advance) begin
         if (!in_frame_ff) begin
            if (in_byte_ff == bsfd_pkg::SOF_CODE) begin
               in_frame_in    = 1'b1;
               esc_pending_in = 1'b0;
               fill_count_in  = '0;
               overflow_in    = 1'b0;
               clear_buf      = 1'b1;
            end
         end else if (in_byte_ff == bsfd_pkg::EOF_CODE) begin
            esc_pending_in = 1'b0;
            in_frame_in    = 1'b0;
         end else if (esc_pending_ff) begin
            esc_pending_in = 1'b0;
            store          = 1'b1;
            store_byte     = in_byte_ff | bsfd_pkg::ESC_OR;
         end else if (in_byte_ff == bsfd_pkg::ESC_CODE) begin
            esc_pending_in = 1'b1;
         end else begin
            store = 1'b1;
         end
         // Store while room remains, otherwise note the overflow.
         if (store) begin
            if (fill_count_ff < CapCount) begin
               write_en      = 1'b1;
               fill_count_in = fill_count_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end
   end

   // Framing state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         esc_pending_ff <= 1'b0;
         fill_count_ff  <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         in_frame_ff    <= in_frame_in;
         esc_pending_ff <= esc_pending_in;
         fill_count_ff  <= fill_count_in;
         overflow_ff    <= overflow_in;
      end
   end

   // Message buffer: cleared at frame start, one entry written per stored byte.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MSG_BYTES; i++) begin
         if (clear_buf) begin
            msg_data_ff[i] <= '0;
         end else if (write_en && (fill_count_ff == bsfd_pkg::COUNT_W'(i))) begin
            msg_data_ff[i] <= store_byte;
         end
      end
   end

   // Pack argument bytes, first argument in the low byte, zero filled.
   always_comb begin
      args_in = '0;
      for (int i = 2; i < MSG_BYTES; i++) begin
         args_in[(i-2)*8 +: 8] = msg_data_ff[i];
      end
   end

   // Output register holds a result until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit_now) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit_now) begin
         rsp_class_ff    <= msg_data_ff[0][7:5];
         rsp_id_ff       <= msg_data_ff[0][4:0];
         rsp_opcode_ff   <= msg_data_ff[1];
         rsp_args_ff     <= args_in;
         rsp_count_ff    <= fill_count_ff;
         rsp_too_long_ff <= overflow_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_msg_class  = rsp_class_ff;
   assign rsp_node_id    = rsp_id_ff;
   assign rsp_opcode     = rsp_opcode_ff;
   assign rsp_args       = rsp_args_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_too_long   = rsp_too_long_ff;

   // The fill count never passes the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CapCount)
      else $error("fill count beyond capacity");

   // An overflow can only be flagged once the buffer is full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (fill_count_ff == CapCount))
      else $error("overflow flagged with room left");

   // A pending escape exists only inside a frame.
   a_escape_in_frame: assert property (@(posedge clock) disable iff (reset)
      esc_pending_ff |-> in_frame_ff)
      else $error("escape pending outside a frame");

   // A decoded end byte closes the frame and presents a result.
   a_emit_result: assert property (@(posedge clock) disable iff (reset)
      (advance && emit_now) |=> (rsp_valid_ff && !in_frame_ff && !esc_pending_ff))
      else $error("end byte did not produce a result");

endmodule
